@@ hdl/c3lb_pkg.sv @@
// Shared types, constants and helpers for the 3x3 line-buffer convolution unit.
package c3lb_pkg;

  localparam int LINE_WIDTH = 512;
  localparam int COL_W      = $clog2(LINE_WIDTH);
  localparam int ROW_W      = 12;
  localparam int FCOLS_W    = 10;
  localparam int PIX_W      = 8;
  localparam int SUM_W      = 16;
  localparam int LS_DW      = 2 * PIX_W;
  localparam int WROW_W     = 3 * PIX_W;
  localparam int TAPS       = 9;
  localparam int APB_AW     = 5;
  localparam int APB_DW     = 32;
  localparam int Q_DEPTH    = 2;
  localparam int Q_AW       = $clog2(Q_DEPTH);
  localparam int Q_CW       = $clog2(Q_DEPTH + 1);

  localparam logic [ROW_W-1:0]   FROWS_RST = ROW_W'(416);
  localparam logic [FCOLS_W-1:0] FCOLS_RST = FCOLS_W'(416);

  typedef enum logic [2:0] {
    REG_ROWS = 3'd0,
    REG_COLS = 3'd1,
    REG_W0   = 3'd2,
    REG_W1   = 3'd3,
    REG_W2   = 3'd4
  } reg_idx_e;

  typedef logic [2:0][WROW_W-1:0] weights_t;

  typedef struct packed {
    logic [TAPS-1:0][SUM_W-1:0] prod;
    logic                       zero;
    logic                       last;
    logic [3:0]                 keep;
    logic [3:0]                 strobe;
    logic                       user;
    logic                       id;
    logic                       dest;
  } item_t;

  function automatic logic [SUM_W-1:0] mul8(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    logic signed [SUM_W-1:0] p;
    p = SUM_W'($signed(a)) * SUM_W'($signed(b));
    return p;
  endfunction

endpackage

@@ hdl/c3lb_ram.sv @@
// Generic single-clock RAM, one write port, one registered read port (read-first).
module c3lb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/c3lb_front.sv @@
// Front end: raster counters, line store, sliding window and tap products.
module c3lb_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           stall_o,
  input  logic [c3lb_pkg::PIX_W-1:0]     pixel_i,
  input  logic [3:0]                     byte_keep_i,
  input  logic [3:0]                     byte_strobe_i,
  input  logic                           side_user_i,
  input  logic                           side_id_i,
  input  logic                           side_dest_i,
  input  logic [c3lb_pkg::ROW_W-1:0]     frame_rows_i,
  input  logic [c3lb_pkg::FCOLS_W-1:0]   frame_cols_i,
  input  c3lb_pkg::weights_t             weights_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output c3lb_pkg::item_t                item_o
);
  import c3lb_pkg::*;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W:0]   cols_eff;
  logic [ROW_W-1:0] rows_eff;
  logic             row_end, frame_end, in_fire, s1_fire;

  logic             s1_v_q;
  logic [PIX_W-1:0] s1_px_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_zero_q, s1_last_q;
  logic [3:0]       s1_keep_q, s1_strobe_q;
  logic             s1_user_q, s1_id_q, s1_dest_q;
  logic             byp_q;
  logic [LS_DW-1:0] byp_data_q, rd_data, ls, wr_data;

  logic [2:0][2:0][PIX_W-1:0] win_q, win_d;
  logic [TAPS-1:0][SUM_W-1:0] prod;

  assign s1_fire = s1_v_q && !q_full_i;
  assign stall_o = s1_v_q && q_full_i;
  assign in_fire = valid_i && !stall_o;

  always_comb begin
    if (frame_cols_i == '0) begin
      cols_eff = (COL_W+1)'(1);
    end else if (32'(frame_cols_i) > LINE_WIDTH) begin
      cols_eff = (COL_W+1)'(LINE_WIDTH);
    end else begin
      cols_eff = (COL_W+1)'(frame_cols_i);
    end
    rows_eff  = (frame_rows_i == '0) ? ROW_W'(1) : frame_rows_i;
    row_end   = {1'b0, col_q} >= (cols_eff - 1'b1);
    frame_end = row_end && (row_q >= (rows_eff - 1'b1));
    priority if (frame_end) begin
      row_d = '0;
      col_d = '0;
    end else if (row_end) begin
      row_d = row_q + 1'b1;
      col_d = '0;
    end else begin
      row_d = row_q;
      col_d = col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
      byp_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        col_q  <= col_d;
        row_q  <= row_d;
        s1_v_q <= 1'b1;
        byp_q  <= s1_fire && (s1_col_q == col_q);
      end else if (s1_fire) begin
        s1_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_px_q     <= pixel_i;
      s1_col_q    <= col_q;
      s1_zero_q   <= (row_q < ROW_W'(2)) || (col_q < COL_W'(2));
      s1_last_q   <= frame_end;
      s1_keep_q   <= byte_keep_i;
      s1_strobe_q <= byte_strobe_i;
      s1_user_q   <= side_user_i;
      s1_id_q     <= side_id_i;
      s1_dest_q   <= side_dest_i;
      byp_data_q  <= wr_data;
    end
  end

  // ls[7:0]: two rows back, ls[15:8]: one row back
  assign ls      = byp_q ? byp_data_q : rd_data;
  assign wr_data = {s1_px_q, ls[LS_DW-1:PIX_W]};

  c3lb_ram #(
    .WIDTH(LS_DW),
    .DEPTH(LINE_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (wr_data),
    .re_i    (in_fire),
    .raddr_i (col_q),
    .rdata_o (rd_data)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
    end
    win_d[0][2] = ls[PIX_W-1:0];
    win_d[1][2] = ls[LS_DW-1:PIX_W];
    win_d[2][2] = s1_px_q;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod[i*3+j] = mul8(win_d[i][j], weights_i[i][PIX_W*j +: PIX_W]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_fire) begin
      win_q <= win_d;
    end
  end

  assign push_o = s1_fire;
  always_comb begin
    item_o.prod   = prod;
    item_o.zero   = s1_zero_q;
    item_o.last   = s1_last_q;
    item_o.keep   = s1_keep_q;
    item_o.strobe = s1_strobe_q;
    item_o.user   = s1_user_q;
    item_o.id     = s1_id_q;
    item_o.dest   = s1_dest_q;
  end

endmodule

@@ hdl/c3lb_queue.sv @@
// Two-entry request queue between front end and back end.
module c3lb_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  c3lb_pkg::item_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output c3lb_pkg::item_t data_o,
  output logic            empty_o
);
  import c3lb_pkg::*;

  item_t             mem_q [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Q_CW-1:0]   cnt_q;

  assign full_o  = cnt_q == Q_CW'(Q_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (32'(wr_ptr_q) == Q_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (32'(rd_ptr_q) == Q_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ hdl/c3lb_back.sv @@
// Back end: sums the nine tap products and holds the output register.
module c3lb_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  c3lb_pkg::item_t             head_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic [c3lb_pkg::SUM_W-1:0]  conv_sum_o,
  output logic                        frame_last_o,
  output logic [3:0]                  out_keep_o,
  output logic [3:0]                  out_strobe_o,
  output logic                        out_user_o,
  output logic                        out_id_o,
  output logic                        out_dest_o
);
  import c3lb_pkg::*;

  logic             out_v_q;
  logic [SUM_W-1:0] sum, s01, s23, s45, s67;

  assign pop_o = !empty_i && (!out_v_q || !stall_i);

  always_comb begin
    s01 = head_i.prod[0] + head_i.prod[1];
    s23 = head_i.prod[2] + head_i.prod[3];
    s45 = head_i.prod[4] + head_i.prod[5];
    s67 = head_i.prod[6] + head_i.prod[7];
    sum = (s01 + s23) + (s45 + s67) + head_i.prod[8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (pop_o) begin
      out_v_q <= 1'b1;
    end else if (!stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      conv_sum_o   <= head_i.zero ? '0 : sum;
      frame_last_o <= head_i.last;
      out_keep_o   <= head_i.keep;
      out_strobe_o <= head_i.strobe;
      out_user_o   <= head_i.user;
      out_id_o     <= head_i.id;
      out_dest_o   <= head_i.dest;
    end
  end

  assign valid_o = out_v_q;

endmodule

@@ hdl/conv3x3_line_buffer_stream_unit.sv @@
// Streaming 3x3 convolution over signed 8-bit pixels with a two-line store.
// Throughput: one pixel per cycle while stall_o is low; line store is a 512 x 16 RAM, read and written once per pixel.
// A taken pixel passes the front-end input register, a queue entry and the output register before valid_o.
// Front end (counters, line store, window, products) and back end (adder, output reg)
// are decoupled by a two-entry queue.
// Reset: counters and window cleared, frame size 416x416, weights 0; line store not cleared.
module conv3x3_line_buffer_stream_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           stall_o,
  input  logic [c3lb_pkg::PIX_W-1:0]     pixel_i,
  input  logic [3:0]                     byte_keep_i,
  input  logic [3:0]                     byte_strobe_i,
  input  logic                           side_user_i,
  input  logic                           side_id_i,
  input  logic                           side_dest_i,
  output logic                           valid_o,
  input  logic                           stall_i,
  output logic [c3lb_pkg::SUM_W-1:0]     conv_sum_o,
  output logic                           frame_last_o,
  output logic [3:0]                     out_keep_o,
  output logic [3:0]                     out_strobe_o,
  output logic                           out_user_o,
  output logic                           out_id_o,
  output logic                           out_dest_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [c3lb_pkg::APB_AW-1:0]    paddr,
  input  logic [c3lb_pkg::APB_DW-1:0]    pwdata,
  output logic [c3lb_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);
  import c3lb_pkg::*;

  logic [ROW_W-1:0]   frame_rows_q;
  logic [FCOLS_W-1:0] frame_cols_q;
  weights_t           weights_q;
  logic               wr_en;
  logic [2:0]         reg_idx;

  item_t              push_item, head_item;
  logic               push, pop, q_full, q_empty;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_rows_q <= FROWS_RST;
      frame_cols_q <= FCOLS_RST;
      weights_q    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ROWS: frame_rows_q <= pwdata[ROW_W-1:0];
        REG_COLS: frame_cols_q <= pwdata[FCOLS_W-1:0];
        REG_W0:   weights_q[0] <= pwdata[WROW_W-1:0];
        REG_W1:   weights_q[1] <= pwdata[WROW_W-1:0];
        REG_W2:   weights_q[2] <= pwdata[WROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROWS: prdata = APB_DW'(frame_rows_q);
      REG_COLS: prdata = APB_DW'(frame_cols_q);
      REG_W0:   prdata = APB_DW'(weights_q[0]);
      REG_W1:   prdata = APB_DW'(weights_q[1]);
      REG_W2:   prdata = APB_DW'(weights_q[2]);
      default:  prdata = '0;
    endcase
  end

  c3lb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .stall_o       (stall_o),
    .pixel_i       (pixel_i),
    .byte_keep_i   (byte_keep_i),
    .byte_strobe_i (byte_strobe_i),
    .side_user_i   (side_user_i),
    .side_id_i     (side_id_i),
    .side_dest_i   (side_dest_i),
    .frame_rows_i  (frame_rows_q),
    .frame_cols_i  (frame_cols_q),
    .weights_i     (weights_q),
    .q_full_i      (q_full),
    .push_o        (push),
    .item_o        (push_item)
  );

  c3lb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (head_item),
    .empty_o (q_empty)
  );

  c3lb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_item),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .conv_sum_o   (conv_sum_o),
    .frame_last_o (frame_last_o),
    .out_keep_o   (out_keep_o),
    .out_strobe_o (out_strobe_o),
    .out_user_o   (out_user_o),
    .out_id_o     (out_id_o),
    .out_dest_o   (out_dest_o)
  );

endmodule

@@ test/conv3x3_line_buffer_stream_unit_tb.sv @@
// Self-checking testbench for the streaming 3x3 line-buffer convolution unit.
module conv3x3_line_buffer_stream_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import c3lb_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [3:0]       keep;
    logic [3:0]       strobe;
    logic             user;
    logic             id;
    logic             dest;
  } pix_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] total;
    logic             last;
    logic [3:0]       keep;
    logic [3:0]       strobe;
    logic             user;
    logic             id;
    logic             dest;
  } conv_res_t;

  localparam int PIX_REQ_W      = $bits(pix_req_t);
  localparam int SPARE_REG      = int'(REG_W2) + 1;
  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS   = 40;
  localparam int TAIL_CYCLES    = 8;
  localparam int PRINT_CAP      = 40;

  logic                clk_i;
  logic                rst_ni;
  logic                valid_i;
  logic                stall_o;
  logic [PIX_W-1:0]    pixel_i;
  logic [3:0]          byte_keep_i;
  logic [3:0]          byte_strobe_i;
  logic                side_user_i;
  logic                side_id_i;
  logic                side_dest_i;
  logic                valid_o;
  logic                stall_i;
  logic [SUM_W-1:0]    conv_sum_o;
  logic                frame_last_o;
  logic [3:0]          out_keep_o;
  logic [3:0]          out_strobe_o;
  logic                out_user_o;
  logic                out_id_o;
  logic                out_dest_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  conv3x3_line_buffer_stream_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .stall_o       (stall_o),
    .pixel_i       (pixel_i),
    .byte_keep_i   (byte_keep_i),
    .byte_strobe_i (byte_strobe_i),
    .side_user_i   (side_user_i),
    .side_id_i     (side_id_i),
    .side_dest_i   (side_dest_i),
    .valid_o       (valid_o),
    .stall_i       (stall_i),
    .conv_sum_o    (conv_sum_o),
    .frame_last_o  (frame_last_o),
    .out_keep_o    (out_keep_o),
    .out_strobe_o  (out_strobe_o),
    .out_user_o    (out_user_o),
    .out_id_o      (out_id_o),
    .out_dest_o    (out_dest_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // shadow of the block: registers, line store, window, raster position
  logic [ROW_W-1:0]        cfg_rows;
  logic [FCOLS_W-1:0]      cfg_cols;
  weights_t                cfg_wts;
  logic signed [PIX_W-1:0] line_mem [2][LINE_WIDTH];
  logic signed [PIX_W-1:0] win [3][3];
  logic [ROW_W-1:0]        row_pos;
  int                      col_pos;

  conv_res_t pending_sums[$];

  int  mismatches   = 0;
  int  results_seen = 0;
  int  frames_seen  = 0;
  int  pixels_sent  = 0;
  int  cfg_writes   = 0;
  int  idle_cycles  = 0;
  int  hold_left    = 0;
  logic hold_req;
  logic no_gaps;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_CAP) begin
      $display("[%0t] result %0d: %s got 0x%0h expected 0x%0h",
               $time, results_seen, what, got, want);
    end
    mismatches++;
  endtask

  function automatic int eff_cols(logic [FCOLS_W-1:0] v);
    if (v == 0) return 1;
    return (v > LINE_WIDTH) ? LINE_WIDTH : int'(v);
  endfunction

  function automatic void model_reset();
    cfg_rows = FROWS_RST;
    cfg_cols = FCOLS_RST;
    cfg_wts  = '0;
    line_mem = '{default: '0};
    win      = '{default: '0};
    row_pos  = '0;
    col_pos  = 0;
  endfunction

  function automatic void model_config(int idx, logic [31:0] val);
    case (idx)
      REG_ROWS: cfg_rows   = val[ROW_W-1:0];
      REG_COLS: cfg_cols   = val[FCOLS_W-1:0];
      REG_W0:   cfg_wts[0] = val[WROW_W-1:0];
      REG_W1:   cfg_wts[1] = val[WROW_W-1:0];
      REG_W2:   cfg_wts[2] = val[WROW_W-1:0];
      default: ;
    endcase
  endfunction

  // advance the window by one pixel and return the result it produces
  function automatic conv_res_t conv_window_step(pix_req_t px);
    int        rows;
    int        cols;
    int        c;
    int        acc;
    logic      last_col;
    conv_res_t res;
    rows = (cfg_rows == 0) ? 1 : int'(cfg_rows);
    cols = eff_cols(cfg_cols);
    c    = (col_pos >= LINE_WIDTH) ? LINE_WIDTH - 1 : col_pos;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2]      = line_mem[0][c];
    win[1][2]      = line_mem[1][c];
    win[2][2]      = px.pixel;
    line_mem[0][c] = line_mem[1][c];
    line_mem[1][c] = px.pixel;
    acc = 0;
    if (row_pos >= 2 && col_pos >= 2) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          acc += int'(win[i][j]) * int'($signed(cfg_wts[i][8*j +: 8]));
        end
      end
    end
    last_col   = col_pos >= cols - 1;
    res.total  = acc[SUM_W-1:0];
    res.last   = last_col && (int'(row_pos) >= rows - 1);
    res.keep   = px.keep;
    res.strobe = px.strobe;
    res.user   = px.user;
    res.id     = px.id;
    res.dest   = px.dest;
    if (res.last) begin
      row_pos = '0;
      col_pos = 0;
    end else if (last_col) begin
      row_pos = row_pos + 1'b1;
      col_pos = 0;
    end else begin
      col_pos++;
    end
    return res;
  endfunction

  function automatic pix_req_t random_pixel();
    pix_req_t px;
    px = pix_req_t'(PIX_REQ_W'($urandom));
    case ($urandom_range(7))
      0: px.pixel = 8'h80;
      1: px.pixel = 8'h7F;
      default: ;
    endcase
    return px;
  endfunction

  function automatic logic [WROW_W-1:0] pick_weight();
    case ($urandom_range(7))
      0: return 24'h808080;
      1: return 24'h7F7F7F;
      2: return '0;
      default: return WROW_W'($urandom);
    endcase
  endfunction

  task automatic wait_results_done();
    valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_sums.size() != 0);
  endtask

  task automatic cfg_write(input int idx, input logic [31:0] val);
    wait_results_done();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx << 2);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    model_config(idx, val);
    cfg_writes++;
    @(posedge clk_i);
  endtask

  task automatic cfg_read_check(input int idx);
    logic [31:0] got;
    logic [31:0] want;
    case (idx)
      REG_ROWS: want = 32'(cfg_rows);
      REG_COLS: want = 32'(cfg_cols);
      REG_W0:   want = 32'(cfg_wts[0]);
      REG_W1:   want = 32'(cfg_wts[1]);
      default:  want = 32'(cfg_wts[2]);
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_AW'(idx << 2);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got      = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) report_mismatch("register readback", got, want);
    @(posedge clk_i);
  endtask

  task automatic set_frame(input int rows, input int cols, input logic [WROW_W-1:0] w0,
                           input logic [WROW_W-1:0] w1, input logic [WROW_W-1:0] w2);
    cfg_write(REG_ROWS, rows);
    cfg_write(REG_COLS, cols);
    cfg_write(REG_W0, 32'(w0));
    cfg_write(REG_W1, 32'(w1));
    cfg_write(REG_W2, 32'(w2));
  endtask

  task automatic send_pixel(input pix_req_t px);
    while (!no_gaps && $urandom_range(99) < 9) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i       <= 1'b1;
    pixel_i       <= px.pixel;
    byte_keep_i   <= px.keep;
    byte_strobe_i <= px.strobe;
    side_user_i   <= px.user;
    side_id_i     <= px.id;
    side_dest_i   <= px.dest;
    do @(posedge clk_i); while (stall_o);
    pending_sums.push_back(conv_window_step(px));
    pixels_sent++;
  endtask

  // result checker
  always @(posedge clk_i) begin : result_check
    conv_res_t want;
    if (rst_ni && valid_o && !stall_i) begin
      results_seen++;
      if (frame_last_o) frames_seen++;
      if (pending_sums.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(conv_sum_o), '0);
      end else begin
        want = pending_sums.pop_front();
        if (conv_sum_o !== want.total) begin
          report_mismatch("conv_sum", 32'(conv_sum_o), 32'(want.total));
        end
        if (frame_last_o !== want.last) begin
          report_mismatch("frame_last", 32'(frame_last_o), 32'(want.last));
        end
        if (out_keep_o !== want.keep) begin
          report_mismatch("out_keep", 32'(out_keep_o), 32'(want.keep));
        end
        if (out_strobe_o !== want.strobe) begin
          report_mismatch("out_strobe", 32'(out_strobe_o), 32'(want.strobe));
        end
        if (out_user_o !== want.user) begin
          report_mismatch("out_user", 32'(out_user_o), 32'(want.user));
        end
        if (out_id_o !== want.id) begin
          report_mismatch("out_id", 32'(out_id_o), 32'(want.id));
        end
        if (out_dest_o !== want.dest) begin
          report_mismatch("out_dest", 32'(out_dest_o), 32'(want.dest));
        end
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      stall_i   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      stall_i   <= 1'b1;
    end else begin
      stall_i <= !no_gaps && ($urandom_range(99) < 9);
    end
  end

  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no request moved for %0d cycles", idle_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic test_registers();
    for (int r = int'(REG_ROWS); r <= int'(REG_W2); r++) begin
      cfg_write(r, '1);
      cfg_read_check(r);
      cfg_write(r, '0);
      cfg_read_check(r);
    end
    cfg_write(SPARE_REG, '1);
    for (int r = int'(REG_ROWS); r <= int'(REG_W2); r++) begin
      cfg_read_check(r);
    end
  endtask

  task automatic test_directed_windows();
    pix_req_t px;
    // full negative window wraps past 16 bits
    set_frame(3, 4, 24'h808080, 24'h808080, 24'h808080);
    for (int i = 0; i < 12; i++) begin
      px.pixel  = (i == 11) ? 8'h7F : 8'h80;
      px.keep   = i[0] ? 4'hF : 4'h0;
      px.strobe = i[1] ? 4'h5 : 4'hA;
      px.user   = i[0];
      px.id     = i[1];
      px.dest   = i[2];
      send_pixel(px);
    end
    // zero sizes act as a 1x1 frame
    set_frame(0, 0, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
    repeat (3) send_pixel(random_pixel());
    // wide row saturates, then shrink columns and rows mid-frame
    set_frame(4095, 1023, 24'h7F807F, 24'h80017F, 24'h01FF80);
    repeat (4) send_pixel(random_pixel());
    cfg_write(REG_COLS, 3);
    send_pixel(random_pixel());
    cfg_write(REG_ROWS, 2);
    repeat (3) send_pixel(random_pixel());
  endtask

  task automatic test_wide_rows();
    set_frame(1, 1023, pick_weight(), pick_weight(), pick_weight());
    no_gaps <= 1'b1;
    repeat (LINE_WIDTH) send_pixel(random_pixel());
    no_gaps <= 1'b0;
    wait_results_done();
  endtask

  task automatic test_output_holdoff();
    set_frame(4, 6, pick_weight(), pick_weight(), pick_weight());
    no_gaps  <= 1'b1;
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    repeat (24) send_pixel(random_pixel());
    no_gaps <= 1'b0;
    wait_results_done();
  endtask

  task automatic test_random_frames();
    int done;
    int n;
    int rows_v;
    int cols_v;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      wait_results_done();
      case ($urandom_range(9))
        0: rows_v = 0;
        1: rows_v = 4095;
        2: rows_v = $urandom_range(4095, 1);
        default: rows_v = $urandom_range(5, 1);
      endcase
      // columns may only grow at a frame start, so every line store read is of written data
      if (row_pos == 0 && col_pos == 0) begin
        case ($urandom_range(9))
          0: cols_v = 0;
          1: cols_v = $urandom_range(1023, 512);
          default: cols_v = $urandom_range(12, 1);
        endcase
      end else begin
        cols_v = $urandom_range(eff_cols(cfg_cols), 0);
      end
      set_frame(rows_v, cols_v, pick_weight(), pick_weight(), pick_weight());
      n = $urandom_range(70, 20);
      repeat (n) send_pixel(random_pixel());
      done += n;
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    valid_i       <= 1'b0;
    pixel_i       <= '0;
    byte_keep_i   <= '0;
    byte_strobe_i <= '0;
    side_user_i   <= 1'b0;
    side_id_i     <= 1'b0;
    side_dest_i   <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    hold_req      <= 1'b0;
    no_gaps       <= 1'b0;
    model_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_registers();
    test_directed_windows();
    test_wide_rows();
    test_output_holdoff();
    test_random_frames();

    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d pixels, %0d results and %0d frame ends over %0d register writes",
             pixels_sent, results_seen, frames_seen, cfg_writes);
    $display("including border, wrap, zero-size, wide-row, resize and hold-off cases");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
